// File: hw/rtl/fcsol_pkg.sv
package fcsol_pkg;

	localparam int DEPTH = 16;
	localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W = $clog2(DEPTH + 1);

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_ACCESS = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] payload;
		logic [31:0] cnt;
	} entry_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic             move_en;
		logic             app_en;
		logic [31:0]      key;
		entry_t           ent;
		logic [POS_W-1:0] pos;
		logic [OCC_W-1:0] occ;
	} bcast_t;

endpackage

// File: hw/rtl/fcsol_cell.sv
module fcsol_cell (
	input  logic                       clk,
	input  logic [fcsol_pkg::POS_W-1:0] idx,
	input  fcsol_pkg::bcast_t          bc,
	input  fcsol_pkg::entry_t          prev_ent,
	input  logic                       run_lo,
	input  logic                       run_hi,
	output fcsol_pkg::entry_t          ent,
	output logic                       match,
	output logic                       run
);
	import fcsol_pkg::*;

	entry_t ent_q;
	logic   valid;
	logic   above;
	logic   at;
	logic   le;

	assign valid = OCC_W'(idx) < bc.occ;
	assign match = valid && (ent_q.key == bc.key);
	assign above = idx < bc.pos;
	assign at    = idx == bc.pos;
	assign le    = ent_q.cnt <= bc.ent.cnt;

	// run: this cell lies in the span from the hit back to its destination
	assign run = at || (above && le && run_hi);
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (bc.move_en && run) begin
			ent_q <= run_lo ? prev_ent : bc.ent;
		end else if (bc.app_en && (OCC_W'(idx) == bc.occ)) begin
			ent_q <= bc.ent;
		end
	end

endmodule

// File: hw/rtl/frequency_count_self_organizing_list_core.sv
// channel | dir | beat contents (low bit up)
// s_*     | in  | tuser: operation; tdata: key[31:0], payload_in[63:32]
// m_*     | out | tuser: status; tdata: payload_out, hit_position, entry_count_out,
//         |     |        total_cost, zero fill
// An item passes three steps: accept, search (all cells compare in parallel),
// commit (on a hit, the span of cells from the hit back to its destination shifts by one).
// The commit waits while the output register holds an untaken beat.
// Reset empties the table and clears the cost; cell contents are not cleared.
module frequency_count_self_organizing_list_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // key[31:0], payload_in[63:32]
	input  logic        s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // payload_out, hit_position, entry_count_out, total_cost
	output logic [1:0]  m_tuser   // status
);
	import fcsol_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SRCH = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t           state_q;
	logic             op_q;
	logic [31:0]      key_q;
	logic [31:0]      pay_q;
	logic [1:0]       st_q;
	logic [POS_W-1:0] pos_q;
	entry_t           hit_q;
	logic [OCC_W-1:0] occ_q;
	logic [31:0]      cost_q;

	logic             vld_q;
	logic [1:0]       o_status_q;
	logic [31:0]      o_pay_q;
	logic [3:0]       o_pos_q;
	logic [4:0]       o_cnt_q;
	logic [31:0]      o_cost_q;

	bcast_t           bc;
	entry_t           ents  [DEPTH];
	logic [DEPTH-1:0] match;
	logic [DEPTH-1:0] run;

	logic             found;
	logic [POS_W-1:0] fpos;
	entry_t           fent;
	logic             full;
	logic             out_free;
	logic             commit;
	logic             mv;
	logic             ap;
	logic [OCC_W-1:0] occ_nxt;
	logic [32:0]      cost_sum;
	logic [31:0]      cost_nxt;

	assign s_tready = state_q == S_IDLE;
	assign out_free = !vld_q || m_tready;
	assign full     = occ_q == OCC_W'(DEPTH);
	assign commit   = (state_q == S_DONE) && out_free;
	assign mv       = commit && (op_q == OP_ACCESS) && (st_q == ST_OK);
	assign ap       = commit && (op_q == OP_APPEND) && (st_q == ST_OK);
	assign occ_nxt  = occ_q + OCC_W'(ap);
	assign cost_sum = {1'b0, cost_q} + 33'(pos_q) + 33'd1;
	assign cost_nxt = mv ? (cost_sum[32] ? CNT_MAX : cost_sum[31:0]) : cost_q;

	assign bc.move_en = mv;
	assign bc.app_en  = ap;
	assign bc.key     = key_q;
	assign bc.ent     = hit_q;
	assign bc.pos     = pos_q;
	assign bc.occ     = occ_q;

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		entry_t prev_ent;
		logic   run_lo;
		logic   run_hi;
		if (j == 0) begin : g_first
			assign prev_ent = '0;
			assign run_lo   = 1'b0;
		end else begin : g_mid
			assign prev_ent = ents[j-1];
			assign run_lo   = run[j-1];
		end
		if (j == DEPTH - 1) begin : g_last
			assign run_hi = 1'b0;
		end else begin : g_inner
			assign run_hi = run[j+1];
		end
		fcsol_cell u_cell (
			.clk      (clk),
			.idx      (POS_W'(j)),
			.bc       (bc),
			.prev_ent (prev_ent),
			.run_lo   (run_lo),
			.run_hi   (run_hi),
			.ent      (ents[j]),
			.match    (match[j]),
			.run      (run[j])
		);
	end

	// first match from the front wins
	always_comb begin
		found = 1'b0;
		fpos  = '0;
		fent  = '0;
		for (int j = DEPTH - 1; j >= 0; j--) begin
			if (match[j]) begin
				found = 1'b1;
				fpos  = POS_W'(j);
				fent  = ents[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			occ_q    <= '0;
			cost_q   <= '0;
			vld_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_SRCH;
				end
				S_SRCH: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			occ_q  <= occ_nxt;
			cost_q <= cost_nxt;
			if (commit) begin
				vld_q <= 1'b1;
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tuser;
			key_q <= s_tdata[31:0];
			pay_q <= s_tdata[63:32];
		end
		if (state_q == S_SRCH) begin
			if (op_q == OP_ACCESS) begin
				st_q        <= found ? ST_OK : ST_MISS;
				pos_q       <= fpos;
				hit_q.key     <= fent.key;
				hit_q.payload <= fent.payload;
				hit_q.cnt     <= (fent.cnt == CNT_MAX) ? CNT_MAX : fent.cnt + 32'd1;
			end else begin
				st_q          <= full ? ST_FULL : ST_OK;
				pos_q         <= '0;
				hit_q.key     <= key_q;
				hit_q.payload <= pay_q;
				hit_q.cnt     <= '0;
			end
		end
		if (commit) begin
			o_status_q <= st_q;
			o_pay_q    <= mv ? hit_q.payload : 32'd0;
			o_pos_q    <= mv ? 4'(pos_q) : 4'd0;
			o_cnt_q    <= 5'(occ_nxt);
			o_cost_q   <= cost_nxt;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tuser  = o_status_q;
	assign m_tdata  = {7'd0, o_cost_q, o_cnt_q, o_pos_q, o_pay_q};

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("occupancy above table depth");

	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_q) |-> $past(state_q == S_DONE))
		else $error("result beat without commit");

	a_access_keeps_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && op_q == OP_ACCESS) |=> occ_q == $past(occ_q))
		else $error("access changed occupancy");

	a_cost_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cost_q >= $past(cost_q))
		else $error("total cost decreased");

	a_hold_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready)
		else $error("input taken while busy");

endmodule

// File: sim/tb_frequency_count_self_organizing_list_core.sv
module tb_frequency_count_self_organizing_list_core;
	import fcsol_pkg::*;

	localparam int N_RANDOM   = 700;
	localparam int PAUSE_AT   = 450;   // sender waits for a drained pipe here
	localparam int HOLD_AFTER = 300;   // results seen before the long sink stall
	localparam int HOLD_LEN   = 300;
	localparam int WDOG_LIMIT = 5000;
	localparam int FILL_LO    = 32 + POS_W + OCC_W + 32;

	typedef struct {
		logic [1:0]       status;
		logic [31:0]      payload;
		logic [POS_W-1:0] pos;
		logic [OCC_W-1:0] occ;
		logic [31:0]      cost;
	} list_result_t;

	typedef struct {
		logic         op;
		logic [31:0]  key;
		logic [31:0]  payload;
		bit           typed;
		list_result_t want;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tuser = OP_APPEND;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;

	frequency_count_self_organizing_list_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// shadow copy of the ordered table
	logic [31:0] tbl_key [DEPTH];
	logic [31:0] tbl_pay [DEPTH];
	logic [31:0] tbl_hits [DEPTH];
	int          tbl_size = 0;
	logic [31:0] cost_total = '0;

	list_result_t pending_results[$];
	logic [31:0]  key_pool[$];

	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int n_hit = 0;
	int n_miss = 0;
	int n_full = 0;
	int idle_cycles = 0;

	function automatic list_result_t predict_list_op(logic op, logic [31:0] key,
		logic [31:0] pay);
		list_result_t r;
		int hit;
		int dst;
		logic [32:0] sum;
		logic [31:0] k, p, c;
		r.status = ST_OK;
		r.payload = '0;
		r.pos = '0;
		if (op == OP_APPEND) begin
			if (tbl_size >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				tbl_key[tbl_size] = key;
				tbl_pay[tbl_size] = pay;
				tbl_hits[tbl_size] = '0;
				tbl_size++;
			end
		end else begin
			hit = -1;
			for (int i = 0; i < tbl_size; i++)
				if (hit < 0 && tbl_key[i] == key)
					hit = i;
			if (hit < 0) begin
				r.status = ST_MISS;
			end else begin
				n_hit++;
				sum = {1'b0, cost_total} + 33'(hit + 1);
				cost_total = sum[32] ? CNT_MAX : sum[31:0];
				if (tbl_hits[hit] != CNT_MAX)
					tbl_hits[hit]++;
				k = tbl_key[hit];
				p = tbl_pay[hit];
				c = tbl_hits[hit];
				// move ahead of every earlier entry with count <= new count
				dst = hit;
				while (dst > 0 && tbl_hits[dst-1] <= c)
					dst--;
				for (int i = hit; i > dst; i--) begin
					tbl_key[i] = tbl_key[i-1];
					tbl_pay[i] = tbl_pay[i-1];
					tbl_hits[i] = tbl_hits[i-1];
				end
				tbl_key[dst] = k;
				tbl_pay[dst] = p;
				tbl_hits[dst] = c;
				r.payload = p;
				r.pos = POS_W'(hit);
			end
		end
		r.occ = OCC_W'(tbl_size);
		r.cost = cost_total;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch at result %0d, %s: got %h want %h",
			results_seen, what, got, want);
	endtask

	task automatic send_beat(logic op, logic [31:0] key, logic [31:0] pay, bit typed,
		list_result_t typed_res);
		list_result_t r;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {pay, key};
		do @(posedge clk); while (!s_tready);
		r = predict_list_op(op, key, pay);
		pending_results.push_back(typed ? typed_res : r);
		items_sent++;
	endtask

	// sink side check
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			case (m_tuser)
				ST_OK:   ;
				ST_MISS: n_miss++;
				ST_FULL: n_full++;
				default: ;
			endcase
			if (pending_results.size() == 0) begin
				report_mismatch("beat with nothing pending", m_tdata[31:0], '0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser != want.status)
					report_mismatch("status", 32'(m_tuser), 32'(want.status));
				if (m_tdata[31:0] != want.payload)
					report_mismatch("payload_out", m_tdata[31:0], want.payload);
				if (m_tdata[32 +: POS_W] != want.pos)
					report_mismatch("hit_position", 32'(m_tdata[32 +: POS_W]),
						32'(want.pos));
				if (m_tdata[32+POS_W +: OCC_W] != want.occ)
					report_mismatch("entry_count_out", 32'(m_tdata[32+POS_W +: OCC_W]),
						32'(want.occ));
				if (m_tdata[32+POS_W+OCC_W +: 32] != want.cost)
					report_mismatch("total_cost", m_tdata[32+POS_W+OCC_W +: 32],
						want.cost);
				if (m_tdata[79:FILL_LO] != '0)
					report_mismatch("zero fill", 32'(m_tdata[79:FILL_LO]), '0);
			end
		end
	end

	// watchdog: cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results pending",
				idle_cycles, pending_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// sink: random back-pressure plus one long stall
	initial begin
		int stall;
		bit held;
		held = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1;
				stall = HOLD_LEN;
			end else if ((results_seen / 120) % 3 == 2) begin
				stall = 0;
			end else begin
				stall = $urandom_range(9, 0);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		script_row_t script [25];
		list_result_t none;
		logic [31:0] key;
		logic op;
		int gap;
		int sel;

		none = '{ST_OK, 32'd0, '0, '0, 32'd0};
		script = '{
			'{OP_ACCESS, 32'h0000_0000, 32'h0000_0000, 1, '{ST_MISS, 0, 0, 0, 0}},
			'{OP_APPEND, 32'h8000_0000, 32'hFFFF_FFFF, 1, '{ST_OK, 0, 0, 1, 0}},
			'{OP_APPEND, 32'h7FFF_FFFF, 32'h0000_0000, 1, '{ST_OK, 0, 0, 2, 0}},
			'{OP_APPEND, 32'h0000_0000, 32'hAAAA_5555, 1, '{ST_OK, 0, 0, 3, 0}},
			'{OP_APPEND, 32'hFFFF_FFFF, 32'h5555_AAAA, 1, '{ST_OK, 0, 0, 4, 0}},
			// duplicate key: later accesses always land on the earlier copy
			'{OP_APPEND, 32'h7FFF_FFFF, 32'h1234_5678, 1, '{ST_OK, 0, 0, 5, 0}},
			'{OP_ACCESS, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, none},
			'{OP_ACCESS, 32'h7FFF_FFFF, 32'h0000_0000, 0, none},
			'{OP_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, none},
			'{OP_ACCESS, 32'h0000_0000, 32'h0000_0000, 0, none},
			'{OP_ACCESS, 32'h0BAD_F00D, 32'h0000_0000, 0, none},
			'{OP_APPEND, 32'hAAAA_5555, 32'h0000_0001, 0, none},
			'{OP_APPEND, 32'h5555_AAAA, 32'h8000_0000, 0, none},
			'{OP_APPEND, 32'h0000_0001, 32'hDEAD_BEEF, 0, none},
			'{OP_APPEND, 32'h0000_0002, 32'h0F0F_F0F0, 0, none},
			'{OP_APPEND, 32'h0000_0003, 32'h1111_2222, 0, none},
			'{OP_APPEND, 32'hFFFF_FFFE, 32'h3333_4444, 0, none},
			'{OP_APPEND, 32'h4000_0000, 32'h5555_6666, 0, none},
			'{OP_APPEND, 32'h3C3C_3C3C, 32'h7777_8888, 0, none},
			'{OP_APPEND, 32'hC3C3_C3C3, 32'h9999_AAAA, 0, none},
			'{OP_APPEND, 32'h0F0F_0F0F, 32'hBBBB_CCCC, 0, none},
			'{OP_APPEND, 32'hF0F0_F0F0, 32'hDDDD_EEEE, 0, none},
			// table is full from here on
			'{OP_APPEND, 32'h1234_5678, 32'hFFFF_FFFF, 0, none},
			'{OP_ACCESS, 32'hF0F0_F0F0, 32'h0000_0000, 0, none},
			'{OP_ACCESS, 32'h0BAD_F00D, 32'hFFFF_FFFF, 0, none}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].op == OP_APPEND)
				key_pool.push_back(script[i].key);
			gap = $urandom_range(9, 0);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			send_beat(script[i].op, script[i].key, script[i].payload, script[i].typed,
				script[i].want);
		end
		void'(key_pool.pop_back());  // last append is refused

		// mostly hits on stored keys so entries keep reordering; some misses
		// and refused appends as noise
		for (int n = 0; n < N_RANDOM; n++) begin
			sel = $urandom_range(99, 0);
			if (sel < 80) begin
				op = OP_ACCESS;
				key = key_pool[$urandom_range(key_pool.size() - 1, 0)];
			end else if (sel < 92) begin
				op = OP_ACCESS;
				key = $urandom;
			end else begin
				op = OP_APPEND;
				key = $urandom;
			end
			gap = ((n / 100) % 3 == 1) ? 0 : $urandom_range(9, 0);
			if (n == PAUSE_AT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end else if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			send_beat(op, key, $urandom, 0, none);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d beats sent (%0d directed, table filled to %0d), %0d results checked",
			items_sent, $size(script), tbl_size, results_seen);
		$display("results: %0d hits, %0d misses, %0d refused appends, cost %0d",
			n_hit, n_miss, n_full, cost_total);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/fcsol_pkg.sv
hw/rtl/fcsol_cell.sv
hw/rtl/frequency_count_self_organizing_list_core.sv
sim/tb_frequency_count_self_organizing_list_core.sv
